// ===== sv/fstp_pkg.sv =====
// Shared types and constants for the format string token parser.
`timescale 1ns / 1ps

package fstp_pkg;

    localparam int ARG_NUMBER_BITS_DEF = 16;
    localparam int CHAR_BITS           = 21;
    localparam int MAX_RESULTS         = 3;
    localparam int QUEUE_DEPTH         = 4;

    localparam logic [CHAR_BITS-1:0] CHAR_PERCENT = CHAR_BITS'(8'h25);
    localparam logic [CHAR_BITS-1:0] CHAR_DOLLAR  = CHAR_BITS'(8'h24);
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = CHAR_BITS'(8'h30);
    localparam logic [CHAR_BITS-1:0] CHAR_NINE    = CHAR_BITS'(8'h39);
    localparam logic [CHAR_BITS-1:0] CHAR_LOWER_D = CHAR_BITS'(8'h64);
    localparam logic [CHAR_BITS-1:0] CHAR_LOWER_I = CHAR_BITS'(8'h69);
    localparam logic [CHAR_BITS-1:0] CHAR_LOWER_S = CHAR_BITS'(8'h73);
    localparam logic [CHAR_BITS-1:0] CHAR_LOWER_F = CHAR_BITS'(8'h66);
    localparam logic [CHAR_BITS-1:0] CHAR_LOWER_E = CHAR_BITS'(8'h65);

    typedef enum logic [2:0] {
        TK_LITERAL  = 3'd0,
        TK_RUN_END  = 3'd1,
        TK_ARGUMENT = 3'd2,
        TK_ERROR    = 3'd3,
        TK_MSG_END  = 3'd4
    } token_kind_t;

    typedef enum logic [1:0] {
        AT_INT    = 2'd0,
        AT_STRING = 2'd1,
        AT_FLOAT  = 2'd2,
        AT_DOUBLE = 2'd3
    } arg_type_t;

    typedef enum logic [1:0] {
        ERR_UNFINISHED      = 2'd0,
        ERR_MIXED_NUMBERING = 2'd1,
        ERR_ARG_ZERO        = 2'd2,
        ERR_UNSUPPORTED     = 2'd3
    } err_code_t;

    typedef enum logic [2:0] {
        PM_TEXT    = 3'd0,
        PM_PERCENT = 3'd1,
        PM_DIGITS  = 3'd2,
        PM_DOLLAR  = 3'd3,
        PM_SKIP    = 3'd4
    } parse_mode_t;

endpackage

// ===== sv/format_string_token_parser.sv =====
// Top level of the format string token parser: character in, token stream out.
//
//  channel | handshake                    | payload
//  --------+------------------------------+-------------------------------------------
//  in      | in_valid / in_stall          | char_code, end_of_message
//  out     | out_valid / out_stall        | token_kind, literal_char, arg_type,
//          |                              | arg_number, error_code, last_of_run
//
// Each character is parsed in the cycle it is accepted; its zero to three tokens land in a
// four-entry token queue and appear on the output from the next cycle, one per cycle while
// out_stall is low. One character per cycle is sustained while characters make at most one
// token each and the output is not stalled; the input stalls whenever the queue holds more
// than one token. rst_n clears the parser state and empties the queue.
`timescale 1ns / 1ps

module format_string_token_parser
    import fstp_pkg::*;
#(
    parameter int ARG_NUMBER_BITS = ARG_NUMBER_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [CHAR_BITS-1:0]       char_code,
    input  logic                       end_of_message,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [2:0]                 token_kind,
    output logic [CHAR_BITS-1:0]       literal_char,
    output logic [1:0]                 arg_type,
    output logic [ARG_NUMBER_BITS-1:0] arg_number,
    output logic [1:0]                 error_code,
    output logic                       last_of_run
);

    localparam int PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
    localparam int WIDE_BITS = ARG_NUMBER_BITS + 4;

    typedef struct packed {
        token_kind_t                kind;
        logic [CHAR_BITS-1:0]       lit;
        arg_type_t                  atype;
        logic [ARG_NUMBER_BITS-1:0] num;
        err_code_t                  err;
        logic                       last;
    } token_t;

    // Parser state.
    parse_mode_t                parse_mode_reg, parse_mode_next;
    logic                       text_pending_reg, text_pending_next;
    logic [ARG_NUMBER_BITS-1:0] digit_value_reg, digit_value_next;
    logic                       digits_seen_reg, digits_seen_next;
    logic                       numbering_used_reg, numbering_used_next;
    logic [ARG_NUMBER_BITS-1:0] next_arg_reg, next_arg_next;

    // Token queue.
    token_t                     queue_reg [QUEUE_DEPTH];
    token_t                     queue_next [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]        count_reg, count_next;

    logic                       accept;
    logic                       pop;
    logic                       is_digit;
    logic                       is_percent;
    logic                       is_dollar;
    logic                       type_ok;
    arg_type_t                  type_sel;
    logic [WIDE_BITS-1:0]       digit_wide;
    logic [ARG_NUMBER_BITS-1:0] digit_sat;
    logic [ARG_NUMBER_BITS-1:0] next_arg_inc;

    logic                       pre_run_end;
    logic                       main_valid;
    token_t                     main_tok;
    logic                       tail_run_end;
    logic                       tail_msg_end;
    logic                       do_number;
    logic                       do_convert;
    logic                       conv_fail_mixed;
    logic [ARG_NUMBER_BITS-1:0] conv_num;

    token_t                     res [MAX_RESULTS];
    logic [1:0]                 res_cnt;
    logic [1:0]                 push_cnt;
    token_t                     head;

    assign in_stall = count_reg > CNT_BITS'(QUEUE_DEPTH - MAX_RESULTS);
    assign accept   = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;

    assign is_percent = char_code == CHAR_PERCENT;
    assign is_dollar  = char_code == CHAR_DOLLAR;
    assign is_digit   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);

    always_comb
    begin
        type_ok  = 1'b1;
        type_sel = AT_INT;
        case (char_code)
            CHAR_LOWER_D, CHAR_LOWER_I: type_sel = AT_INT;
            CHAR_LOWER_S:               type_sel = AT_STRING;
            CHAR_LOWER_F:               type_sel = AT_FLOAT;
            CHAR_LOWER_E:               type_sel = AT_DOUBLE;
            default:                    type_ok  = 1'b0;
        endcase
    end

    // value * 10 + digit; the four extra bits always hold the product, so any of them
    // set means the number has passed the maximum.
    assign digit_wide = (WIDE_BITS'(digit_value_reg) << 3)
                      + (WIDE_BITS'(digit_value_reg) << 1)
                      + WIDE_BITS'(char_code[3:0]);
    assign digit_sat  = (|digit_wide[WIDE_BITS-1 -: 4]) ? '1
                                                         : digit_wide[ARG_NUMBER_BITS-1:0];
    assign next_arg_inc = (next_arg_reg != '1) ? next_arg_reg + ARG_NUMBER_BITS'(1)
                                               : next_arg_reg;

    // Next state and the tokens of the current character.
    always_comb
    begin
        parse_mode_next     = parse_mode_reg;
        text_pending_next   = text_pending_reg;
        digit_value_next    = digit_value_reg;
        digits_seen_next    = digits_seen_reg;
        numbering_used_next = numbering_used_reg;
        next_arg_next       = next_arg_reg;
        pre_run_end         = 1'b0;
        main_valid          = 1'b0;
        main_tok            = '0;
        tail_run_end        = 1'b0;
        tail_msg_end        = 1'b0;
        do_number           = 1'b0;
        do_convert          = 1'b0;
        conv_fail_mixed     = 1'b0;
        conv_num            = '0;

        case (parse_mode_reg)
            PM_TEXT:
            begin
                if (is_percent && !end_of_message)
                begin
                    parse_mode_next = PM_PERCENT;
                end
                else
                begin
                    main_valid        = 1'b1;
                    main_tok.kind     = TK_LITERAL;
                    main_tok.lit      = char_code;
                    text_pending_next = 1'b1;
                end
            end
            PM_PERCENT:
            begin
                if (is_percent)
                begin
                    main_valid        = 1'b1;
                    main_tok.kind     = TK_LITERAL;
                    main_tok.lit      = char_code;
                    text_pending_next = 1'b1;
                    parse_mode_next   = PM_TEXT;
                end
                else
                begin
                    pre_run_end       = text_pending_reg;
                    text_pending_next = 1'b0;
                    do_number         = 1'b1;
                end
            end
            PM_DIGITS: do_number  = 1'b1;
            PM_DOLLAR: do_convert = 1'b1;
            default:   ;
        endcase

        if (do_number)
        begin
            if (is_digit)
            begin
                digit_value_next = digit_sat;
                digits_seen_next = 1'b1;
                parse_mode_next  = PM_DIGITS;
            end
            else if (is_dollar)
            begin
                parse_mode_next = PM_DOLLAR;
            end
            else
            begin
                do_convert = 1'b1;
            end
            if ((is_digit || is_dollar) && end_of_message)
            begin
                main_valid      = 1'b1;
                main_tok.kind   = TK_ERROR;
                main_tok.err    = ERR_UNFINISHED;
                parse_mode_next = PM_SKIP;
            end
        end

        if (do_convert)
        begin
            if (digits_seen_reg)
            begin
                conv_num            = digit_value_reg;
                numbering_used_next = 1'b1;
            end
            else if (numbering_used_reg)
            begin
                conv_fail_mixed = 1'b1;
            end
            else
            begin
                conv_num      = next_arg_reg;
                next_arg_next = next_arg_inc;
            end

            main_valid = 1'b1;
            if (conv_fail_mixed)
            begin
                main_tok.kind   = TK_ERROR;
                main_tok.err    = ERR_MIXED_NUMBERING;
                parse_mode_next = PM_SKIP;
            end
            else if (conv_num == '0)
            begin
                main_tok.kind   = TK_ERROR;
                main_tok.err    = ERR_ARG_ZERO;
                parse_mode_next = PM_SKIP;
            end
            else if (!type_ok)
            begin
                main_tok.kind   = TK_ERROR;
                main_tok.err    = ERR_UNSUPPORTED;
                parse_mode_next = PM_SKIP;
            end
            else
            begin
                main_tok.kind    = TK_ARGUMENT;
                main_tok.atype   = type_sel;
                main_tok.num     = conv_num;
                parse_mode_next  = PM_TEXT;
                digit_value_next = '0;
                digits_seen_next = 1'b0;
            end
        end

        // The message ends here: close it unless an error already did, then start over.
        if (end_of_message)
        begin
            if (parse_mode_next != PM_SKIP)
            begin
                tail_run_end = text_pending_next;
                tail_msg_end = 1'b1;
            end
            parse_mode_next     = PM_TEXT;
            text_pending_next   = 1'b0;
            digit_value_next    = '0;
            digits_seen_next    = 1'b0;
            numbering_used_next = 1'b0;
            next_arg_next       = ARG_NUMBER_BITS'(1);
        end
    end

    // Pack the tokens of this character in order and mark the final one.
    always_comb
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            res[k] = '0;
        end
        res_cnt = 2'd0;
        if (pre_run_end)
        begin
            res[res_cnt].kind = TK_RUN_END;
            res_cnt           = res_cnt + 2'd1;
        end
        if (main_valid)
        begin
            res[res_cnt] = main_tok;
            res_cnt      = res_cnt + 2'd1;
        end
        if (tail_run_end)
        begin
            res[res_cnt].kind = TK_RUN_END;
            res_cnt           = res_cnt + 2'd1;
        end
        if (tail_msg_end)
        begin
            res[res_cnt].kind = TK_MSG_END;
            res_cnt           = res_cnt + 2'd1;
        end
        case (res_cnt)
            2'd1:    res[0].last = 1'b1;
            2'd2:    res[1].last = 1'b1;
            2'd3:    res[2].last = 1'b1;
            default: ;
        endcase
    end

    assign push_cnt = accept ? res_cnt : 2'd0;

    always_comb
    begin
        queue_next = queue_reg;
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (2'(k) < push_cnt)
            begin
                queue_next[wr_ptr_reg + PTR_BITS'(k)] = res[k];
            end
        end
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + CNT_BITS'(push_cnt) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_mode_reg     <= PM_TEXT;
            text_pending_reg   <= 1'b0;
            digit_value_reg    <= '0;
            digits_seen_reg    <= 1'b0;
            numbering_used_reg <= 1'b0;
            next_arg_reg       <= ARG_NUMBER_BITS'(1);
        end
        else if (accept)
        begin
            parse_mode_reg     <= parse_mode_next;
            text_pending_reg   <= text_pending_next;
            digit_value_reg    <= digit_value_next;
            digits_seen_reg    <= digits_seen_next;
            numbering_used_reg <= numbering_used_next;
            next_arg_reg       <= next_arg_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        queue_reg <= queue_next;
    end

    assign head         = queue_reg[rd_ptr_reg];
    assign out_valid    = count_reg != '0;
    assign token_kind   = head.kind;
    assign literal_char = head.lit;
    assign arg_type     = head.atype;
    assign arg_number   = head.num;
    assign error_code   = head.err;
    assign last_of_run  = head.last;

endmodule

// ===== sv/fstp_checker.sv =====
// Port-level checks for the format string token parser, bound to its top level.
`timescale 1ns / 1ps

module fstp_checker
    import fstp_pkg::*;
#(
    parameter int ARG_NUMBER_BITS = ARG_NUMBER_BITS_DEF
)
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic [CHAR_BITS-1:0]       char_code,
    input logic                       end_of_message,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [2:0]                 token_kind,
    input logic [CHAR_BITS-1:0]       literal_char,
    input logic [1:0]                 arg_type,
    input logic [ARG_NUMBER_BITS-1:0] arg_number,
    input logic [1:0]                 error_code,
    input logic                       last_of_run
);

    // A request that is held back stays offered with the same character.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(char_code) && $stable(end_of_message))
        else $error("stalled input request changed");

    // A token that is held back must keep its kind, character, number and last mark on the output.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(token_kind)
            && $stable(literal_char) && $stable(arg_number) && $stable(last_of_run))
        else $error("stalled output token changed");

    // Message end and error tokens always close the tokens of their character.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind == TK_MSG_END || token_kind == TK_ERROR) |-> last_of_run)
        else $error("message end or error token not marked last");

    // Argument numbers start at one.
    a_arg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == TK_ARGUMENT |-> arg_number != '0)
        else $error("argument token with number zero");

    // Run end and message end tokens carry zero in every data field.
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind != TK_LITERAL && token_kind != TK_ARGUMENT
            && token_kind != TK_ERROR
            |-> literal_char == '0 && arg_number == '0 && arg_type == '0 && error_code == '0)
        else $error("run end or message end token carries data");

endmodule

bind format_string_token_parser fstp_checker #(.ARG_NUMBER_BITS(ARG_NUMBER_BITS)) u_fstp_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .char_code      (char_code),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .token_kind     (token_kind),
    .literal_char   (literal_char),
    .arg_type       (arg_type),
    .arg_number     (arg_number),
    .error_code     (error_code),
    .last_of_run    (last_of_run)
);

// ===== tb/token_stream_checker.sv =====
// Token stream checker: predicts the parser's tokens from accepted characters and compares.
`timescale 1ns / 1ps

module token_stream_checker
    import fstp_pkg::*;
#(
    parameter int ARG_NUMBER_BITS = ARG_NUMBER_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [CHAR_BITS-1:0]       char_code,
    input  logic                       end_of_message,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [2:0]                 token_kind,
    input  logic [CHAR_BITS-1:0]       literal_char,
    input  logic [1:0]                 arg_type,
    input  logic [ARG_NUMBER_BITS-1:0] arg_number,
    input  logic [1:0]                 error_code,
    input  logic                       last_of_run,
    output int                         errors,
    output int                         pending
);

    localparam logic [63:0] NUM_LIMIT = (64'd1 << ARG_NUMBER_BITS) - 64'd1;
    localparam logic [ARG_NUMBER_BITS-1:0] NUM_MAX = '1;

    typedef struct {
        token_kind_t                kind;
        logic [CHAR_BITS-1:0]       lit;
        arg_type_t                  atype;
        logic [ARG_NUMBER_BITS-1:0] num;
        err_code_t                  err;
        logic                       last;
    } token_t;

    token_t expected_tokens[$];
    token_t char_tokens[$];

    parse_mode_t                mode;
    logic                       text_pending;
    logic [ARG_NUMBER_BITS-1:0] digit_value;
    logic                       digits_seen;
    logic                       numbering_used;
    logic [ARG_NUMBER_BITS-1:0] next_arg;

    task automatic report(string msg);
        if (errors < 40)
            $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic clear_message();
        mode           = PM_TEXT;
        text_pending   = 1'b0;
        digit_value    = '0;
        digits_seen    = 1'b0;
        numbering_used = 1'b0;
        next_arg       = ARG_NUMBER_BITS'(1);
    endtask

    task automatic emit_token(token_kind_t kind, logic [CHAR_BITS-1:0] lit, arg_type_t atype,
                              logic [ARG_NUMBER_BITS-1:0] num, err_code_t err);
        token_t tok;
        tok.kind  = kind;
        tok.lit   = lit;
        tok.atype = atype;
        tok.num   = num;
        tok.err   = err;
        tok.last  = 1'b0;
        char_tokens = {char_tokens, tok};
    endtask

    task automatic close_run();
        if (text_pending)
        begin
            emit_token(TK_RUN_END, '0, AT_INT, '0, ERR_UNFINISHED);
            text_pending = 1'b0;
        end
    endtask

    task automatic abort_message(err_code_t err);
        emit_token(TK_ERROR, '0, AT_INT, '0, err);
        mode = PM_SKIP;
    endtask

    task automatic convert(logic [CHAR_BITS-1:0] c);
        logic [ARG_NUMBER_BITS-1:0] num;
        arg_type_t                  atype;
        if (digits_seen)
        begin
            num = digit_value;
            numbering_used = 1'b1;
        end
        else if (numbering_used)
        begin
            abort_message(ERR_MIXED_NUMBERING);
            return;
        end
        else
        begin
            num = next_arg;
            if (next_arg != NUM_MAX)
                next_arg = next_arg + ARG_NUMBER_BITS'(1);
        end
        if (num == 0)
        begin
            abort_message(ERR_ARG_ZERO);
            return;
        end
        case (c)
            CHAR_LOWER_D, CHAR_LOWER_I: atype = AT_INT;
            CHAR_LOWER_S:               atype = AT_STRING;
            CHAR_LOWER_F:               atype = AT_FLOAT;
            CHAR_LOWER_E:               atype = AT_DOUBLE;
            default:
            begin
                abort_message(ERR_UNSUPPORTED);
                return;
            end
        endcase
        emit_token(TK_ARGUMENT, '0, atype, num, ERR_UNFINISHED);
        mode        = PM_TEXT;
        digit_value = '0;
        digits_seen = 1'b0;
    endtask

    // Handles a character after the percent sign or after digits.
    task automatic number_or_convert(logic [CHAR_BITS-1:0] c, logic eom);
        logic [63:0] acc;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            acc = 64'(digit_value) * 64'd10 + 64'(c - CHAR_ZERO);
            digit_value = (acc > NUM_LIMIT) ? NUM_MAX : acc[ARG_NUMBER_BITS-1:0];
            digits_seen = 1'b1;
            mode = PM_DIGITS;
            if (eom)
                abort_message(ERR_UNFINISHED);
        end
        else if (c == CHAR_DOLLAR)
        begin
            mode = PM_DOLLAR;
            if (eom)
                abort_message(ERR_UNFINISHED);
        end
        else
        begin
            convert(c);
        end
    endtask

    task automatic parse_char(logic [CHAR_BITS-1:0] c, logic eom);
        char_tokens.delete();
        case (mode)
            PM_TEXT:
            begin
                if (c == CHAR_PERCENT && !eom)
                    mode = PM_PERCENT;
                else
                begin
                    emit_token(TK_LITERAL, c, AT_INT, '0, ERR_UNFINISHED);
                    text_pending = 1'b1;
                end
            end
            PM_PERCENT:
            begin
                if (c == CHAR_PERCENT)
                begin
                    emit_token(TK_LITERAL, c, AT_INT, '0, ERR_UNFINISHED);
                    text_pending = 1'b1;
                    mode = PM_TEXT;
                end
                else
                begin
                    close_run();
                    number_or_convert(c, eom);
                end
            end
            PM_DIGITS: number_or_convert(c, eom);
            PM_DOLLAR: convert(c);
            default: ;
        endcase
        if (eom)
        begin
            if (mode != PM_SKIP)
            begin
                close_run();
                emit_token(TK_MSG_END, '0, AT_INT, '0, ERR_UNFINISHED);
            end
            clear_message();
        end
        if (char_tokens.size() > 0)
            char_tokens[char_tokens.size()-1].last = 1'b1;
        expected_tokens = {expected_tokens, char_tokens};
    endtask

    task automatic check_token();
        token_t want;
        if (expected_tokens.size() == 0)
        begin
            report($sformatf("unexpected token kind %0d", token_kind));
            return;
        end
        want = expected_tokens.pop_front();
        if (token_kind !== want.kind)
            report($sformatf("token_kind got %0d expected %0d", token_kind, want.kind));
        if (literal_char !== want.lit)
            report($sformatf("literal_char got %0h expected %0h", literal_char, want.lit));
        if (arg_type !== want.atype)
            report($sformatf("arg_type got %0d expected %0d", arg_type, want.atype));
        if (arg_number !== want.num)
            report($sformatf("arg_number got %0d expected %0d", arg_number, want.num));
        if (error_code !== want.err)
            report($sformatf("error_code got %0d expected %0d", error_code, want.err));
        if (last_of_run !== want.last)
            report($sformatf("last_of_run got %0b expected %0b", last_of_run, want.last));
    endtask

    // A request is predicted before tokens are checked, so queue order holds even when both
    // channels move at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_tokens.delete();
            clear_message();
            errors = 0;
            pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                parse_char(char_code, end_of_message);
            if (out_valid && !out_stall)
                check_token();
            pending <= expected_tokens.size();
        end
    end

endmodule

// ===== tb/tb_format_string_token_parser.sv =====
// Testbench top for the format string token parser: stimulus, stall control and verdict.
`timescale 1ns / 1ps

module tb_format_string_token_parser;
    import fstp_pkg::*;

    localparam int ARG_BITS    = ARG_NUMBER_BITS_DEF;
    localparam int STALL_LIMIT = 2000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [CHAR_BITS-1:0] char_code = '0;
    logic                 end_of_message = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [2:0]           token_kind;
    logic [CHAR_BITS-1:0] literal_char;
    logic [1:0]           arg_type;
    logic [ARG_BITS-1:0]  arg_number;
    logic [1:0]           error_code;
    logic                 last_of_run;

    int errors;
    int pending;
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int chars_sent = 0;
    int quiet_cycles = 0;

    logic [CHAR_BITS-1:0] msg_chars[$];
    logic [CHAR_BITS-1:0] conv_letters[5] =
        '{CHAR_LOWER_D, CHAR_LOWER_I, CHAR_LOWER_S, CHAR_LOWER_F, CHAR_LOWER_E};

    format_string_token_parser #(.ARG_NUMBER_BITS(ARG_BITS)) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_code      (char_code),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .token_kind     (token_kind),
        .literal_char   (literal_char),
        .arg_type       (arg_type),
        .arg_number     (arg_number),
        .error_code     (error_code),
        .last_of_run    (last_of_run)
    );

    token_stream_checker #(.ARG_NUMBER_BITS(ARG_BITS)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_code      (char_code),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .token_kind     (token_kind),
        .literal_char   (literal_char),
        .arg_type       (arg_type),
        .arg_number     (arg_number),
        .error_code     (error_code),
        .last_of_run    (last_of_run),
        .errors         (errors),
        .pending        (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    // The run is ended when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic append_char(logic [CHAR_BITS-1:0] c);
        msg_chars = {msg_chars, c};
    endtask

    // Returns right after the edge at which the request was taken.
    task automatic send_char(logic [CHAR_BITS-1:0] c, logic eom);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        char_code      <= c;
        end_of_message <= eom;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_message();
        foreach (msg_chars[i])
            send_char(msg_chars[i], i == msg_chars.size() - 1);
    endtask

    task automatic send_text(string s);
        msg_chars.delete();
        for (int i = 0; i < s.len(); i++)
            append_char(CHAR_BITS'(s[i]));
        send_message();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Mostly well-formed messages; some carry noisy escapes, mixed numbering or a cut tail.
    task automatic build_random_message();
        int                   style;
        int                   kind;
        int                   keep;
        bit                   noisy;
        bit                   numbered;
        logic [CHAR_BITS-1:0] ch;
        msg_chars.delete();
        style    = $urandom_range(9);
        noisy    = (style >= 7);
        numbered = 1'($urandom_range(1));
        repeat ($urandom_range(1, 6))
        begin
            kind = $urandom_range(9);
            if (kind < 4)
            begin
                if ($urandom_range(1))
                    ch = CHAR_BITS'($urandom_range(32, 126));
                else
                    ch = CHAR_BITS'($urandom_range(0, 21'h10FFFF));
                if (ch == CHAR_PERCENT && !noisy)
                    ch = CHAR_ZERO;
                append_char(ch);
            end
            else if (kind == 4)
            begin
                append_char(CHAR_PERCENT);
                append_char(CHAR_PERCENT);
            end
            else
            begin
                append_char(CHAR_PERCENT);
                if (noisy && $urandom_range(3) == 0)
                    numbered = !numbered;
                if (numbered)
                begin
                    append_char(CHAR_ZERO + CHAR_BITS'($urandom_range(noisy ? 0 : 1, 9)));
                    repeat ($urandom_range(0, 2))
                        append_char(CHAR_ZERO + CHAR_BITS'($urandom_range(9)));
                    if ($urandom_range(1))
                        append_char(CHAR_DOLLAR);
                end
                else if (noisy && $urandom_range(7) == 0)
                    append_char(CHAR_DOLLAR);
                if (noisy && $urandom_range(2) == 0)
                begin
                    case ($urandom_range(3))
                        0: ch = CHAR_DOLLAR;
                        1: ch = CHAR_PERCENT;
                        2: ch = CHAR_ZERO + CHAR_BITS'($urandom_range(9));
                        default: ch = CHAR_BITS'($urandom_range(32, 126));
                    endcase
                    append_char(ch);
                end
                else
                    append_char(conv_letters[$urandom_range(4)]);
            end
        end
        if (style == 9)
        begin
            keep = $urandom_range(1, msg_chars.size());
            while (msg_chars.size() > keep)
                void'(msg_chars.pop_back());
        end
    endtask

    task automatic random_phase(int target);
        while (chars_sent < target)
        begin
            build_random_message();
            send_message();
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        in_idle_pct  = 14;
        out_idle_pct = 46;
        send_text("%");
        send_text("a%%");
        send_text("%1$s%e");
        send_text("%0i");
        send_text("x%q");
        send_text("%7");
        send_text("%$");
        send_text("%99999f");
        msg_chars.delete();
        append_char(CHAR_BITS'(21'h10FFFF));
        append_char('0);
        append_char(CHAR_PERCENT);
        append_char(CHAR_LOWER_D);
        send_message();
        wait_drained();
        random_phase(chars_sent + 75);

        in_idle_pct  = 46;
        out_idle_pct = 14;
        random_phase(chars_sent + 75);

        in_idle_pct  = 0;
        out_idle_pct = 0;
        random_phase(chars_sent + 75);

        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
